@@ design/clo_pkg.sv @@
// Shared types, constants and helper functions for the clothoid point generator.
`default_nettype none
package clo_pkg;

    localparam int ATAN_ENTRIES = 20;

    localparam logic signed [30:0] TWO_PI_Q24  = 31'sd105414357;
    localparam logic signed [30:0] PI_Q24      = 31'sd52707179;
    localparam logic signed [30:0] HALF_PI_Q24 = 31'sd26353589;
    localparam logic signed [26:0] CORDIC_GAIN_Q24 = 27'sd10188014;
    localparam logic [16:0]        ONE_Q16 = 17'd65536;
    localparam logic signed [19:0] PIX_CENTER_Q4 = 20'sd1600;
    localparam logic [4:0]         PC_RESET = 5'd10;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_ACCEPT    = 5'd1;
    localparam t_op OP_DIVF_GO   = 5'd2;
    localparam t_op OP_DIVF_END  = 5'd3;
    localparam t_op OP_DIVW_GO   = 5'd4;
    localparam t_op OP_DIVW_END  = 5'd5;
    localparam t_op OP_MUL_VS    = 5'd6;
    localparam t_op OP_MUL_SS    = 5'd7;
    localparam t_op OP_MUL_ULO   = 5'd8;
    localparam t_op OP_MUL_UHI   = 5'd9;
    localparam t_op OP_ANG_ADD   = 5'd10;
    localparam t_op OP_RED_MOD   = 5'd11;
    localparam t_op OP_RED_FOLD  = 5'd12;
    localparam t_op OP_RED_HALF  = 5'd13;
    localparam t_op OP_CORDIC    = 5'd14;
    localparam t_op OP_CORD_OUT  = 5'd15;
    localparam t_op OP_INIT_COPY = 5'd16;
    localparam t_op OP_MUL_IX    = 5'd17;
    localparam t_op OP_MUL_IY    = 5'd18;
    localparam t_op OP_MUL_HX    = 5'd19;
    localparam t_op OP_MUL_HY    = 5'd20;
    localparam t_op OP_FIN_Y     = 5'd21;
    localparam t_op OP_EMIT      = 5'd22;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic red_ok;
        logic cordic_last;
        logic last_point;
        logic out_free;
    } t_sts;

    // Arctangent of 2^-i in Q.24 radians.
    function automatic logic signed [30:0] atan_q24(input logic [4:0] idx);
        logic signed [30:0] a;
        unique case (idx)
            5'd0:  a = 31'sd13176795;
            5'd1:  a = 31'sd7778716;
            5'd2:  a = 31'sd4110060;
            5'd3:  a = 31'sd2086331;
            5'd4:  a = 31'sd1047214;
            5'd5:  a = 31'sd524117;
            5'd6:  a = 31'sd262123;
            5'd7:  a = 31'sd131069;
            5'd8:  a = 31'sd65536;
            5'd9:  a = 31'sd32768;
            5'd10: a = 31'sd16384;
            5'd11: a = 31'sd8192;
            5'd12: a = 31'sd4096;
            5'd13: a = 31'sd2048;
            5'd14: a = 31'sd1024;
            5'd15: a = 31'sd512;
            5'd16: a = 31'sd256;
            5'd17: a = 31'sd128;
            5'd18: a = 31'sd64;
            5'd19: a = 31'sd32;
            default: a = 31'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [22:0] v);
        logic signed [17:0] r;
        if (v > 23'sd131071) begin
            r = 18'sd131071;
        end else if (v < -23'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

    // Screen coordinate: (100 - p) truncated toward zero, p in Q.4.
    function automatic logic signed [14:0] to_pixel(input logic signed [17:0] p);
        logic signed [19:0] q;
        logic signed [19:0] qa;
        logic signed [15:0] d;
        logic signed [14:0] r;
        q  = PIX_CENTER_Q4 - 20'(p);
        qa = q[19] ? q + 20'sd15 : q;
        d  = 16'(qa >>> 4);
        if (d > 16'sd16383) begin
            r = 15'sd16383;
        end else if (d < -16'sd16384) begin
            r = -15'sd16384;
        end else begin
            r = d[14:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/clothoid_point_generator.sv @@
// Top level of the clothoid point generator: controller, datapath and port checks.
//
//  Channel | Dir | Handshake                 | Beat contents
//  in      | in  | i_in_valid / o_in_stall   | pose, heading, scale, rate, accel, travelled
//  out     | out | o_out_valid / i_out_stall | position, pixel, point index, last mark
//  cfg     | in  | i_cfg_wr_en               | point count, 5 bits
//
// The time a request takes grows with n, the clamped point count, and with S, the CORDIC
// iteration count, plus the angle-reduction steps of each evaluation; the single shared
// multiplier and the iterative CORDIC set it.
// The two divisions run one quotient bit per cycle.
// Reset is synchronous and active low; the point count returns to 10.
// A stalled output holds the datapath in its emit step; the next request is taken
// after the last point is placed in the output register.
`default_nettype none
module clothoid_point_generator #(
    parameter int MAX_POINTS   = 16,
    parameter int CORDIC_STEPS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_pose_x,
    input  logic signed [15:0] i_pose_y,
    input  logic signed [15:0] i_start_heading,
    input  logic [14:0]        i_scale_length,
    input  logic signed [15:0] i_heading_rate,
    input  logic signed [15:0] i_heading_accel,
    input  logic signed [15:0] i_travelled,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_plot_x,
    output logic signed [17:0] o_plot_y,
    output logic signed [14:0] o_pixel_col,
    output logic signed [14:0] o_pixel_row,
    output logic [3:0]         o_point_index,
    output logic               o_last_point,
    input  logic               i_cfg_wr_en,
    input  logic [4:0]         i_cfg_wr_data
);
    import clo_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;

    clo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    clo_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_pose_x        (i_pose_x),
        .i_pose_y        (i_pose_y),
        .i_start_heading (i_start_heading),
        .i_scale_length  (i_scale_length),
        .i_heading_rate  (i_heading_rate),
        .i_heading_accel (i_heading_accel),
        .i_travelled     (i_travelled),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_plot_x        (o_plot_x),
        .o_plot_y        (o_plot_y),
        .o_pixel_col     (o_pixel_col),
        .o_pixel_row     (o_pixel_row),
        .o_point_index   (o_point_index),
        .o_last_point    (o_last_point)
    );

    assign o_in_stall = busy;

    // An accepted request keeps the input side stalled on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a request was taken");

    // A point that is not the last one leaves the request still in progress.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_point) |=> o_in_stall)
        else $error("request ended before its last point");

    // Nothing follows the last point of a request on the next cycle.
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_point) |=> !o_out_valid)
        else $error("output beat right after a last point");
endmodule
`default_nettype wire

@@ design/clo_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module clo_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient
);
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_dsr;
    logic [16:0] rem_sh;
    logic [16:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[31]};
    assign ge     = rem_sh >= {1'b0, r_dsr};
    assign diff   = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= 16'd0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so its top bit drops.
            r_rem <= ge ? diff[15:0] : rem_sh[15:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

@@ design/clo_dp.sv @@
// Datapath: operand registers, shared multiplier, angle reduction, CORDIC and output register.
`default_nettype none
module clo_dp #(
    parameter int MAX_POINTS   = 16,
    parameter int CORDIC_STEPS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clo_pkg::t_cmd       i_cmd,
    output clo_pkg::t_sts       o_sts,
    input  logic                i_cfg_wr_en,
    input  logic [4:0]          i_cfg_wr_data,
    input  logic signed [15:0]  i_pose_x,
    input  logic signed [15:0]  i_pose_y,
    input  logic signed [15:0]  i_start_heading,
    input  logic [14:0]         i_scale_length,
    input  logic signed [15:0]  i_heading_rate,
    input  logic signed [15:0]  i_heading_accel,
    input  logic signed [15:0]  i_travelled,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [17:0]  o_plot_x,
    output logic signed [17:0]  o_plot_y,
    output logic signed [14:0]  o_pixel_col,
    output logic signed [14:0]  o_pixel_row,
    output logic [3:0]          o_point_index,
    output logic                o_last_point
);
    import clo_pkg::*;

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int KW = $clog2(MAX_POINTS);
    localparam int CS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic [4:0] CS_LAST = 5'(CS - 1);

    logic [4:0]          r_pc;
    logic                r_out_valid;

    logic signed [15:0]  r_x0, r_y0, r_ph0, r_v, r_u, r_t;
    logic [14:0]         r_h;
    logic [NW-1:0]       r_n;
    logic [KW-1:0]       r_k;
    logic                r_need_div;
    logic [16:0]         r_frac, r_w, r_s, r_sa;
    logic [32:0]         r_ss;
    logic signed [45:0]  r_prod, r_plo;
    logic signed [30:0]  r_ang;
    logic signed [26:0]  r_x, r_y;
    logic [4:0]          r_it;
    logic                r_flip;
    logic signed [26:0]  r_c0, r_s0, r_c1, r_s1;
    logic signed [27:0]  r_ix, r_iy;
    logic signed [17:0]  r_px, r_py;

    logic [NW-1:0]       n_clamp;
    logic signed [27:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [45:0]  mul_p;
    logic signed [50:0]  uss;
    logic signed [26:0]  x_sh, y_sh;
    logic signed [30:0]  atan_v;
    logic signed [15:0]  h_s;
    logic                div_start;
    logic [31:0]         div_dividend;
    logic [15:0]         div_divisor;
    logic                div_busy;
    logic [31:0]         div_q;
    logic [31:0]         k_ext;

    always_comb begin
        if (r_pc == 5'd0) begin
            n_clamp = NW'(1);
        end else if (32'(r_pc) > MAX_POINTS) begin
            n_clamp = NW'(MAX_POINTS);
        end else begin
            n_clamp = NW'(r_pc);
        end
    end

    assign h_s = $signed({1'b0, i_scale_length});

    // Divider operands: travelled fraction first, then the step width.
    assign div_start    = (i_cmd.op == OP_DIVF_GO) || (i_cmd.op == OP_DIVW_GO);
    assign div_dividend = (i_cmd.op == OP_DIVF_GO) ? {1'b0, r_t[14:0], 16'd0}
                                                   : 32'(ONE_Q16 - r_frac);
    assign div_divisor  = (i_cmd.op == OP_DIVF_GO) ? {1'b0, r_h} : 16'(r_n);

    clo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_VS: begin
                mul_a = 28'(r_v);
                mul_b = $signed({1'b0, r_sa});
            end
            OP_MUL_SS: begin
                mul_a = $signed({11'd0, r_sa});
                mul_b = $signed({1'b0, r_sa});
            end
            OP_MUL_ULO: begin
                mul_a = 28'(r_u);
                mul_b = $signed({2'b00, r_prod[15:0]});
            end
            OP_MUL_UHI: begin
                mul_a = 28'(r_u);
                mul_b = $signed({1'b0, r_ss[32:16]});
            end
            OP_MUL_IX: begin
                mul_a = 28'(r_c0) + 28'(r_c1);
                mul_b = $signed({1'b0, r_w});
            end
            OP_MUL_IY: begin
                mul_a = 28'(r_s0) + 28'(r_s1);
                mul_b = $signed({1'b0, r_w});
            end
            OP_MUL_HX: begin
                mul_a = r_ix;
                mul_b = $signed({3'b000, r_h});
            end
            OP_MUL_HY: begin
                mul_a = r_iy;
                mul_b = $signed({3'b000, r_h});
            end
            default: begin
                mul_a = 28'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign uss    = (51'(r_prod) <<< 16) + 51'(r_plo);
    assign x_sh   = r_x >>> r_it;
    assign y_sh   = r_y >>> r_it;
    assign atan_v = atan_q24(r_it);
    assign k_ext  = 32'(r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pc <= i_cfg_wr_data;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (i_cmd.op)
            OP_ACCEPT: begin
                r_x0  <= i_pose_x;
                r_y0  <= i_pose_y;
                r_ph0 <= i_start_heading;
                r_h   <= i_scale_length;
                r_v   <= i_heading_rate;
                r_u   <= i_heading_accel;
                r_t   <= i_travelled;
                r_n   <= n_clamp;
                r_k   <= '0;
                r_s   <= 17'd0;
                r_sa  <= 17'd0;
                r_ix  <= 28'sd0;
                r_iy  <= 28'sd0;
                r_need_div <= (i_travelled > 16'sd0) && (i_travelled < h_s);
                r_frac <= (i_travelled > 16'sd0) ? ONE_Q16 : 17'd0;
            end
            OP_DIVF_END: r_frac <= div_q[16:0];
            OP_DIVW_END: r_w <= div_q[16:0];
            OP_MUL_SS: r_ang <= (31'(r_ph0) <<< 12) + 31'(r_prod >>> 4);
            OP_MUL_ULO: r_ss <= r_prod[32:0];
            OP_MUL_UHI: r_plo <= r_prod;
            OP_ANG_ADD: r_ang <= r_ang + 31'(uss >>> 20);
            OP_RED_MOD: begin
                if (r_ang[30]) begin
                    r_ang <= r_ang + TWO_PI_Q24;
                end else if (r_ang >= TWO_PI_Q24) begin
                    r_ang <= r_ang - TWO_PI_Q24;
                end
            end
            OP_RED_FOLD: begin
                if (r_ang > PI_Q24) begin
                    r_ang <= r_ang - TWO_PI_Q24;
                end
            end
            OP_RED_HALF: begin
                if (r_ang > HALF_PI_Q24) begin
                    r_ang  <= r_ang - PI_Q24;
                    r_flip <= 1'b1;
                end else if (r_ang < -HALF_PI_Q24) begin
                    r_ang  <= r_ang + PI_Q24;
                    r_flip <= 1'b1;
                end else begin
                    r_flip <= 1'b0;
                end
                r_x  <= CORDIC_GAIN_Q24;
                r_y  <= 27'sd0;
                r_it <= 5'd0;
            end
            OP_CORDIC: begin
                if (!r_ang[30]) begin
                    r_x   <= r_x - y_sh;
                    r_y   <= r_y + x_sh;
                    r_ang <= r_ang - atan_v;
                end else begin
                    r_x   <= r_x + y_sh;
                    r_y   <= r_y - x_sh;
                    r_ang <= r_ang + atan_v;
                end
                r_it <= r_it + 5'd1;
            end
            OP_CORD_OUT: begin
                r_c1 <= r_flip ? -r_x : r_x;
                r_s1 <= r_flip ? -r_y : r_y;
            end
            OP_INIT_COPY: begin
                r_c0 <= r_c1;
                r_s0 <= r_s1;
                r_sa <= r_s + r_w;
            end
            OP_MUL_IY: r_ix <= r_ix + 28'(r_prod >>> 17);
            OP_MUL_HX: begin
                r_iy <= r_iy + 28'(r_prod >>> 17);
                r_s  <= r_s + r_w;
                r_c0 <= r_c1;
                r_s0 <= r_s1;
            end
            OP_MUL_HY: r_px <= sat18(23'((r_prod + 46'sd8388608) >>> 24) + 23'(r_x0));
            OP_FIN_Y:  r_py <= sat18(23'((r_prod + 46'sd8388608) >>> 24) + 23'(r_y0));
            OP_EMIT: begin
                o_plot_x      <= r_px;
                o_plot_y      <= r_py;
                o_pixel_col   <= to_pixel(r_py);
                o_pixel_row   <= to_pixel(r_px);
                o_point_index <= k_ext[3:0];
                o_last_point  <= (k_ext == 32'(r_n) - 32'd1);
                r_k           <= r_k + KW'(1);
                r_sa          <= r_s + r_w;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    assign o_sts.need_div    = r_need_div;
    assign o_sts.div_busy    = div_busy;
    assign o_sts.red_ok      = !r_ang[30] && (r_ang < TWO_PI_Q24);
    assign o_sts.cordic_last = (r_it == CS_LAST);
    assign o_sts.last_point  = (k_ext == 32'(r_n) - 32'd1);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;
endmodule
`default_nettype wire

@@ design/clo_ctrl.sv @@
// Controller state machine that sequences the datapath through one request.
`default_nettype none
module clo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  clo_pkg::t_sts  i_sts,
    output clo_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import clo_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_CHECK     = 5'd1;
    localparam logic [4:0] S_DIVF_GO   = 5'd2;
    localparam logic [4:0] S_DIVF_WAIT = 5'd3;
    localparam logic [4:0] S_DIVW_GO   = 5'd4;
    localparam logic [4:0] S_DIVW_WAIT = 5'd5;
    localparam logic [4:0] S_MUL_VS    = 5'd6;
    localparam logic [4:0] S_MUL_SS    = 5'd7;
    localparam logic [4:0] S_MUL_ULO   = 5'd8;
    localparam logic [4:0] S_MUL_UHI   = 5'd9;
    localparam logic [4:0] S_ANG_ADD   = 5'd10;
    localparam logic [4:0] S_RED_MOD   = 5'd11;
    localparam logic [4:0] S_RED_FOLD  = 5'd12;
    localparam logic [4:0] S_RED_HALF  = 5'd13;
    localparam logic [4:0] S_CORDIC    = 5'd14;
    localparam logic [4:0] S_CORD_OUT  = 5'd15;
    localparam logic [4:0] S_INIT_COPY = 5'd16;
    localparam logic [4:0] S_MUL_IX    = 5'd17;
    localparam logic [4:0] S_MUL_IY    = 5'd18;
    localparam logic [4:0] S_MUL_HX    = 5'd19;
    localparam logic [4:0] S_MUL_HY    = 5'd20;
    localparam logic [4:0] S_FIN_Y     = 5'd21;
    localparam logic [4:0] S_EMIT      = 5'd22;

    logic [4:0] r_state, n_state;
    logic       r_first, n_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_first  = r_first;
        o_cmd.op = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: n_state = i_sts.need_div ? S_DIVF_GO : S_DIVW_GO;
            S_DIVF_GO: begin
                o_cmd.op = OP_DIVF_GO;
                n_state  = S_DIVF_WAIT;
            end
            S_DIVF_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = OP_DIVF_END;
                    n_state  = S_DIVW_GO;
                end
            end
            S_DIVW_GO: begin
                o_cmd.op = OP_DIVW_GO;
                n_state  = S_DIVW_WAIT;
            end
            S_DIVW_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = OP_DIVW_END;
                    n_first  = 1'b1;
                    n_state  = S_MUL_VS;
                end
            end
            S_MUL_VS: begin
                o_cmd.op = OP_MUL_VS;
                n_state  = S_MUL_SS;
            end
            S_MUL_SS: begin
                o_cmd.op = OP_MUL_SS;
                n_state  = S_MUL_ULO;
            end
            S_MUL_ULO: begin
                o_cmd.op = OP_MUL_ULO;
                n_state  = S_MUL_UHI;
            end
            S_MUL_UHI: begin
                o_cmd.op = OP_MUL_UHI;
                n_state  = S_ANG_ADD;
            end
            S_ANG_ADD: begin
                o_cmd.op = OP_ANG_ADD;
                n_state  = S_RED_MOD;
            end
            S_RED_MOD: begin
                // One turn is added or removed per cycle until the angle lies in [0, 2pi).
                o_cmd.op = OP_RED_MOD;
                if (i_sts.red_ok) begin
                    n_state = S_RED_FOLD;
                end
            end
            S_RED_FOLD: begin
                o_cmd.op = OP_RED_FOLD;
                n_state  = S_RED_HALF;
            end
            S_RED_HALF: begin
                o_cmd.op = OP_RED_HALF;
                n_state  = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.op = OP_CORDIC;
                if (i_sts.cordic_last) begin
                    n_state = S_CORD_OUT;
                end
            end
            S_CORD_OUT: begin
                o_cmd.op = OP_CORD_OUT;
                n_state  = r_first ? S_INIT_COPY : S_MUL_IX;
            end
            S_INIT_COPY: begin
                o_cmd.op = OP_INIT_COPY;
                n_first  = 1'b0;
                n_state  = S_MUL_VS;
            end
            S_MUL_IX: begin
                o_cmd.op = OP_MUL_IX;
                n_state  = S_MUL_IY;
            end
            S_MUL_IY: begin
                o_cmd.op = OP_MUL_IY;
                n_state  = S_MUL_HX;
            end
            S_MUL_HX: begin
                o_cmd.op = OP_MUL_HX;
                n_state  = S_MUL_HY;
            end
            S_MUL_HY: begin
                o_cmd.op = OP_MUL_HY;
                n_state  = S_FIN_Y;
            end
            S_FIN_Y: begin
                o_cmd.op = OP_FIN_Y;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = i_sts.last_point ? S_IDLE : S_MUL_VS;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire
